// ===== design/biopc_pkg.sv =====
// Shared types and constants of the block I/O pattern classifier.
package biopc_pkg;

	localparam int unsigned SECTOR_SHIFT = 9;

	typedef enum logic [1:0] {
		ST_COUNTED  = 2'd0,
		ST_FIRST    = 2'd1,
		ST_FILTERED = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		CFG_FILTER_ENABLE = 1'b0,
		CFG_TARGET_DEVICE = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [31:0] device;
		logic [63:0] start_sector;
		logic [31:0] sector_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] sequential_total;
		logic [63:0] random_total;
		logic [63:0] byte_total;
	} result_t;

	// Item as it travels along the row of table cells.
	typedef struct packed {
		logic        active;
		logic        done;
		status_t     status;
		logic [31:0] device;
		logic [63:0] start_sector;
		logic [31:0] sector_count;
		logic [63:0] seq_total;
		logic [63:0] rnd_total;
		logic [63:0] byte_total;
	} token_t;

endpackage

// ===== design/biopc_cell.sv =====
// One table cell: holds one device entry and passes the item on to the next cell.
module biopc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  biopc_pkg::token_t tok_in,
	output biopc_pkg::token_t tok_out
);

	logic        valid_q;
	logic [31:0] device_q;
	logic [63:0] end_q;
	logic [63:0] seq_q;
	logic [63:0] rnd_q;
	logic [63:0] bytes_q;
	biopc_pkg::token_t tok_q;

	logic        pending;
	logic        hit;
	logic        alloc;
	logic        had_end;
	logic        is_seq;
	logic [63:0] seq_n;
	logic [63:0] rnd_n;
	logic [63:0] bytes_n;
	logic [63:0] end_n;
	logic [31:0] incr_bytes;
	biopc_pkg::token_t tok_n;

	always_comb begin
		pending    = tok_in.active && !tok_in.done;
		hit        = pending && valid_q && (device_q == tok_in.device);
		// Entries fill from the low end, so the first free cell means the device is new.
		alloc      = pending && !valid_q;
		had_end    = (end_q != 64'd0);
		is_seq     = (end_q == tok_in.start_sector);
		incr_bytes = {tok_in.sector_count[31-biopc_pkg::SECTOR_SHIFT:0],
			{biopc_pkg::SECTOR_SHIFT{1'b0}}};
		end_n      = tok_in.start_sector + {32'd0, tok_in.sector_count};
		seq_n      = seq_q;
		rnd_n      = rnd_q;
		bytes_n    = bytes_q;
		if (had_end) begin
			seq_n   = seq_q + {63'd0, is_seq};
			rnd_n   = rnd_q + {63'd0, !is_seq};
			bytes_n = bytes_q + {32'd0, incr_bytes};
		end

		tok_n = tok_in;
		if (hit) begin
			tok_n.done       = 1'b1;
			tok_n.status     = had_end ? biopc_pkg::ST_COUNTED : biopc_pkg::ST_FIRST;
			tok_n.seq_total  = seq_n;
			tok_n.rnd_total  = rnd_n;
			tok_n.byte_total = bytes_n;
		end else if (alloc) begin
			tok_n.done       = 1'b1;
			tok_n.status     = biopc_pkg::ST_FIRST;
			tok_n.seq_total  = 64'd0;
			tok_n.rnd_total  = 64'd0;
			tok_n.byte_total = 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_n;
			if (alloc) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			end_q   <= end_n;
			seq_q   <= seq_n;
			rnd_q   <= rnd_n;
			bytes_q <= bytes_n;
		end else if (alloc) begin
			device_q <= tok_in.device;
			end_q    <= end_n;
			seq_q    <= 64'd0;
			rnd_q    <= 64'd0;
			bytes_q  <= 64'd0;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== design/block_io_pattern_classifier_top.sv =====
// Top level of the block I/O pattern classifier.
// Each accepted item walks a row of TABLE_ENTRIES cells, one cell per cycle, and each cell
// holds one device entry; the matching cell, or the first free one, updates its entry in
// place, unless the item is filtered. The item is registered at the input and in each cell,
// and the result strobe is registered from the last cell; busy drops so that the next item
// can be taken in the cycle the result is shown, and no new item is taken before then. The
// result is shown for exactly one cycle and cannot be held off.
module block_io_pattern_classifier_top #(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  biopc_pkg::in_item_t item,
	output logic                result_valid,
	output biopc_pkg::result_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);

	logic               busy_q;
	logic               filter_enable_q;
	logic [31:0]        target_device_q;
	logic               result_valid_q;
	biopc_pkg::result_t result_q;
	biopc_pkg::token_t  tok0_q;
	biopc_pkg::token_t  tok [TABLE_ENTRIES+1];
	biopc_pkg::token_t  tail;
	logic               accept;

	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;
	assign tok[0]    = tok0_q;
	assign tail      = tok[TABLE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b0;
			target_device_q <= 32'd0;
		end else if (cfg_valid) begin
			case (biopc_pkg::cfg_index_t'(cfg_index))
				biopc_pkg::CFG_FILTER_ENABLE: filter_enable_q <= cfg_data[0];
				biopc_pkg::CFG_TARGET_DEVICE: target_device_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			tok0_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			tok0_q.active <= accept;
			if (accept) begin
				busy_q              <= 1'b1;
				tok0_q.device       <= item.device;
				tok0_q.start_sector <= item.start_sector;
				tok0_q.sector_count <= item.sector_count;
				tok0_q.seq_total    <= 64'd0;
				tok0_q.rnd_total    <= 64'd0;
				tok0_q.byte_total   <= 64'd0;
				// A filtered item still walks the row but no cell touches it.
				if (filter_enable_q && (target_device_q != item.device)) begin
					tok0_q.done   <= 1'b1;
					tok0_q.status <= biopc_pkg::ST_FILTERED;
				end else begin
					tok0_q.done   <= 1'b0;
					tok0_q.status <= biopc_pkg::ST_FULL;
				end
			end else if (tail.active) begin
				busy_q <= 1'b0;
			end
			result_valid_q <= tail.active;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.active) begin
			if (tail.done) begin
				result_q.status           <= tail.status;
				result_q.sequential_total <= tail.seq_total;
				result_q.random_total     <= tail.rnd_total;
				result_q.byte_total       <= tail.byte_total;
			end else begin
				result_q.status           <= biopc_pkg::ST_FULL;
				result_q.sequential_total <= 64'd0;
				result_q.random_total     <= 64'd0;
				result_q.byte_total       <= 64'd0;
			end
		end
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		biopc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign busy         = busy_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== design/biopc_checker.sv =====
// Port-level checks of the classifier, bound to the top level.
module biopc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                result_valid,
	input biopc_pkg::result_t  result
);

	// An accepted item raises busy, which the design holds until its result comes out; only the rise is checked here.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	// A result only follows a cycle in which an item was in flight.
	a_result_owned: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without an item in flight");

	// One item gives one result strobe, never two in a row.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// Dropped items report zero counters.
	a_dropped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == biopc_pkg::ST_FILTERED ||
		result.status == biopc_pkg::ST_FULL) |->
		(result.sequential_total == 64'd0) && (result.random_total == 64'd0) &&
		(result.byte_total == 64'd0))
		else $error("dropped item reports nonzero counters");

endmodule

bind block_io_pattern_classifier_top biopc_checker u_biopc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
